>>> src/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and constants for the DDA line rasteriser.
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    // request kinds carried on s_tuser
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_NEXT  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;    // start beat taken: latch endpoints, seed dividers
        logic iter;    // one divider iteration
        logic first;   // first iteration (no shift)
        logic fin;     // write increments and point count
        logic emit;    // next beat with active line: output point, advance
    } dda_cmd_t;

    typedef struct packed {
        logic active;  // points still to emit
    } dda_sts_t;

endpackage

>>> src/dda_div.sv
// ----------------------------------------------------------------------------
// dda_div
// Bit-serial restoring divider, one quotient bit per cycle while iter is high, MSB first.
// Computes (num << (QUO_BITS-1)) / den for num <= den.
// ----------------------------------------------------------------------------
module dda_div #(
    parameter int NUM_BITS = dda_pkg::COORD_BITS_DEF,
    parameter int QUO_BITS = dda_pkg::FRAC_BITS_DEF + 1
) (
    input  logic                aclk,
    input  logic                load,
    input  logic                iter,
    input  logic                first,
    input  logic [NUM_BITS-1:0] num,
    input  logic [NUM_BITS-1:0] den,
    output logic [QUO_BITS-1:0] quo
);

    logic [NUM_BITS-1:0] rem_reg, rem_next;
    logic [QUO_BITS-1:0] quo_reg, quo_next;
    logic [NUM_BITS:0]   trial;
    logic                ge;

    always_comb begin
        // remainder stays below den, so the shifted value fits one extra bit
        trial    = first ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        ge       = trial >= {1'b0, den};
        rem_next = ge ? NUM_BITS'(trial - {1'b0, den}) : trial[NUM_BITS-1:0];
        quo_next = {quo_reg[QUO_BITS-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg <= num;
            quo_reg <= '0;
        end else if (iter) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

>>> src/dda_dp.sv
// ----------------------------------------------------------------------------
// dda_dp
// Datapath: deltas, step count, per-axis dividers, accumulators and the
// output payload register.
// ----------------------------------------------------------------------------
module dda_dp #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dda_pkg::dda_cmd_t             cmd,
    output dda_pkg::dda_sts_t             sts,
    input  logic signed [COORD_BITS-1:0]  x_start,
    input  logic signed [COORD_BITS-1:0]  y_start,
    input  logic signed [COORD_BITS-1:0]  x_end,
    input  logic signed [COORD_BITS-1:0]  y_end,
    output logic signed [COORD_BITS-1:0]  pixel_x,
    output logic signed [COORD_BITS-1:0]  pixel_y,
    output logic                          last_pixel
);

    localparam int ACC_BITS  = COORD_BITS + FRAC_BITS + 1;
    localparam int STEP_BITS = FRAC_BITS + 2;
    localparam int QUO_BITS  = FRAC_BITS + 1;

    logic [COORD_BITS:0]          dx, dy;
    logic [COORD_BITS:0]          adx_w, ady_w;
    logic [COORD_BITS-1:0]        adx, ady, steps;

    logic [COORD_BITS-1:0]        steps_reg;
    logic                         x_neg_reg, y_neg_reg;
    logic [ACC_BITS-1:0]          x_acc_reg, y_acc_reg;
    logic [STEP_BITS-1:0]         x_step_reg, y_step_reg;
    logic [COORD_BITS-1:0]        left_reg;
    logic [COORD_BITS-1:0]        pix_x_reg, pix_y_reg;
    logic                         last_reg;

    logic [QUO_BITS-1:0]          x_quo, y_quo;
    logic [STEP_BITS-1:0]         x_qe, y_qe;
    logic [COORD_BITS-1:0]        x_trunc, y_trunc;

    always_comb begin
        dx    = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
        dy    = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
        adx_w = dx[COORD_BITS] ? -dx : dx;
        ady_w = dy[COORD_BITS] ? -dy : dy;
        adx   = adx_w[COORD_BITS-1:0];
        ady   = ady_w[COORD_BITS-1:0];
        steps = (adx > ady) ? adx : ady;
        x_qe  = {1'b0, x_quo};
        y_qe  = {1'b0, y_quo};
    end

    dda_div #(.NUM_BITS(COORD_BITS), .QUO_BITS(QUO_BITS)) u_div_x (
        .aclk  (aclk),
        .load  (cmd.load),
        .iter  (cmd.iter),
        .first (cmd.first),
        .num   (adx),
        .den   (steps_reg),
        .quo   (x_quo)
    );

    dda_div #(.NUM_BITS(COORD_BITS), .QUO_BITS(QUO_BITS)) u_div_y (
        .aclk  (aclk),
        .load  (cmd.load),
        .iter  (cmd.iter),
        .first (cmd.first),
        .num   (ady),
        .den   (steps_reg),
        .quo   (y_quo)
    );

    // integer part truncated towards zero: floor, plus one if negative with
    // a non-zero fraction
    function automatic logic [COORD_BITS-1:0] trunc_acc(input logic [ACC_BITS-1:0] a);
        logic [COORD_BITS:0] ip;
        logic                inc;
        ip  = a[ACC_BITS-1:FRAC_BITS];
        inc = a[ACC_BITS-1] & (|a[FRAC_BITS-1:0]);
        ip  = ip + {{COORD_BITS{1'b0}}, inc};
        return ip[COORD_BITS-1:0];
    endfunction

    always_comb begin
        x_trunc = trunc_acc(x_acc_reg);
        y_trunc = trunc_acc(y_acc_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            steps_reg <= steps;
            x_neg_reg <= dx[COORD_BITS];
            y_neg_reg <= dy[COORD_BITS];
            x_acc_reg <= {{1'b0 ^ x_start[COORD_BITS-1]}, x_start, {FRAC_BITS{1'b0}}};
            y_acc_reg <= {{1'b0 ^ y_start[COORD_BITS-1]}, y_start, {FRAC_BITS{1'b0}}};
        end else if (cmd.emit) begin
            x_acc_reg <= x_acc_reg
                       + {{(ACC_BITS-STEP_BITS){x_step_reg[STEP_BITS-1]}}, x_step_reg};
            y_acc_reg <= y_acc_reg
                       + {{(ACC_BITS-STEP_BITS){y_step_reg[STEP_BITS-1]}}, y_step_reg};
        end
        if (cmd.fin) begin
            x_step_reg <= x_neg_reg ? -x_qe : x_qe;
            y_step_reg <= y_neg_reg ? -y_qe : y_qe;
        end
        if (cmd.emit) begin
            pix_x_reg <= x_trunc;
            pix_y_reg <= y_trunc;
            last_reg  <= (left_reg == COORD_BITS'(1));
        end
    end

    // point count is control state: a line is only live once it is written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else if (cmd.load) begin
            left_reg <= '0;
        end else if (cmd.fin) begin
            left_reg <= steps_reg;
        end else if (cmd.emit) begin
            left_reg <= left_reg - COORD_BITS'(1);
        end
    end

    assign sts.active = (left_reg != '0);
    assign pixel_x    = pix_x_reg;
    assign pixel_y    = pix_y_reg;
    assign last_pixel = last_reg;

endmodule

>>> src/dda_ctrl.sv
// ----------------------------------------------------------------------------
// dda_ctrl
// Controller: sequences the divide after a start beat, gates the input
// handshake and owns the output valid flag.
// ----------------------------------------------------------------------------
module dda_ctrl #(
    parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output dda_pkg::dda_cmd_t cmd,
    input  dda_pkg::dda_sts_t sts
);

    localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

    dda_pkg::state_t       state_reg, state_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  accept;
    logic                  div_last;

    assign div_last = (cnt_reg == CNT_BITS'(FRAC_BITS));

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            dda_pkg::ST_IDLE: begin
                cnt_next = '0;
                if (cmd.load) begin
                    state_next = dda_pkg::ST_DIV;
                end
            end
            dda_pkg::ST_DIV: begin
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (div_last) begin
                    state_next = dda_pkg::ST_FIN;
                end
            end
            dda_pkg::ST_FIN: begin
                state_next = dda_pkg::ST_IDLE;
            end
            default: begin
                state_next = dda_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_tready  = 1'b0;
        cmd       = '0;
        case (state_reg)
            dda_pkg::ST_IDLE: begin
                s_tready = aresetn && (!out_valid_reg || m_tready);
            end
            dda_pkg::ST_DIV: begin
                cmd.iter  = 1'b1;
                cmd.first = (cnt_reg == '0);
            end
            dda_pkg::ST_FIN: begin
                cmd.fin = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
        accept   = s_tvalid && s_tready;
        cmd.load = accept && (s_tuser == dda_pkg::REQ_START);
        cmd.emit = accept && (s_tuser == dda_pkg::REQ_NEXT) && sts.active;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dda_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

>>> src/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasteriser: start beats load a line, next beats return its points.
// ----------------------------------------------------------------------------
// A start beat (s_tuser low) loads both endpoints and returns nothing; the
// input then stays not-ready through the divider iterations and the write
// of the increments, while a bit-serial restoring divider per axis forms
// the Q.FRAC_BITS increments, one quotient bit per cycle. Next beats
// (s_tuser high) are taken one per cycle and each returns one point, valid
// the cycle after the beat, from the start point onwards, m_tlast marking
// the final one; the end point is never returned.
// A next beat with no line left, and any beat of a zero-length line, returns
// nothing. A single output register holds the point: a new beat is taken in
// the cycle the held point leaves, but while a point waits on a low m_tready
// the input is not ready.
module dda_line_rasterizer #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // x_start, y_start, x_end, y_end
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]    s_tdata,
    // req_type
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // pixel_x, pixel_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0]    m_tdata,
    output logic                                 m_tlast
);

    localparam int OUT_BITS = ((2*COORD_BITS+7)/8)*8;

    dda_pkg::dda_cmd_t            cmd;
    dda_pkg::dda_sts_t            sts;
    logic signed [COORD_BITS-1:0] pixel_x, pixel_y;

    dda_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    dda_dp #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .x_start    (s_tdata[COORD_BITS-1:0]),
        .y_start    (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .x_end      (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .y_end      (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (m_tlast)
    );

    assign m_tdata = OUT_BITS'({pixel_y, pixel_x});

    // a start beat never produces a point
    a_start_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && s_tvalid && s_tready && s_tuser == dda_pkg::REQ_START)
        |=> !m_tvalid)
        else $error("point emitted for a start beat");

    // the input closes while the increments are formed
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == dda_pkg::REQ_START) |=> !s_tready)
        else $error("input ready during divide");

    // a next beat with no line left produces nothing
    a_idle_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && s_tvalid && s_tready && s_tuser == dda_pkg::REQ_NEXT
         && !sts.active) |=> !m_tvalid)
        else $error("point emitted with no active line");

    // last point of a line leaves no line active
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) && m_tlast |-> !sts.active)
        else $error("line still active after last point");

endmodule
